// ===== hdl/zipcrypto_stream_decryptor_assert.svh =====
// Assertion macros used by the decryptor module.
`ifndef ZIPCRYPTO_STREAM_DECRYPTOR_ASSERT_SVH
`define ZIPCRYPTO_STREAM_DECRYPTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZCD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("zcd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ZCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("zcd assertion failed");

`endif

// ===== hdl/zcd_pkg.sv =====
package zcd_pkg;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned OpW   = 2;

  localparam logic [KeyW-1:0] KEY_ZERO_INIT = 32'h1234_5678;
  localparam logic [KeyW-1:0] KEY_ONE_INIT  = 32'h2345_6789;
  localparam logic [KeyW-1:0] KEY_TWO_INIT  = 32'h3456_7890;
  localparam logic [KeyW-1:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [KeyW-1:0] KEY_ONE_MULT  = 32'd134775813;

  localparam logic [OpW-1:0] OP_RESTART = 2'd0;
  localparam logic [OpW-1:0] OP_ABSORB  = 2'd1;
  localparam logic [OpW-1:0] OP_DECRYPT = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [ByteW-1:0] data_byte;
  } zcd_in_t;

  typedef struct packed {
    logic [ByteW-1:0] plain_byte;
    logic             matches_check;
  } zcd_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KS,
    S_K0,
    S_K1,
    S_K2
  } zcd_state_e;

  typedef logic [KeyW-1:0] crc_lut_t [256];

  // Byte-wise table of the reflected CRC-32, built at elaboration.
  function automatic crc_lut_t crc_gen_table();
    crc_lut_t tab;
    logic [KeyW-1:0] x;
    for (int i = 0; i < 256; i++) begin
      x = KeyW'(i);
      for (int k = 0; k < 8; k++) begin
        x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
      end
      tab[i] = x;
    end
    return tab;
  endfunction

  localparam crc_lut_t CRC_LUT = crc_gen_table();

  function automatic logic [KeyW-1:0] crc_step(logic [KeyW-1:0] crc, logic [ByteW-1:0] b);
    logic [ByteW-1:0] idx;
    idx = crc[ByteW-1:0] ^ b;
    return CRC_LUT[idx] ^ (crc >> ByteW);
  endfunction

endpackage

// ===== hdl/zipcrypto_stream_decryptor.sv =====
// Restart items finish in S_IDLE; absorb items pass through S_K0, S_K1 and S_K2, and
// decrypt items through S_KS, S_K0, S_K1 and S_K2, before the next item is accepted; a
// decrypt item waits in S_K0 while the last result stalls, then raises out_valid_o.
// One registered 32x32 multiplier serves the keystream product and the key one update.
// Reset (rst_ni low, asynchronous) loads the initial keys, clears the check register and
// empties the result register.
module zipcrypto_stream_decryptor
  import zcd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  zcd_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output zcd_out_t         out_data_o
);

  zcd_state_e       state_q, state_d;
  logic [OpW-1:0]   op_q, op_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic [KeyW-1:0]  key0_q, key0_d, key1_q, key1_d, key2_q, key2_d;
  logic [ByteW-1:0] check_q;
  zcd_out_t         out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             mul_en;
  logic [KeyW-1:0]  mul_a, mul_b, prod, key1_new, ks_word;
  logic [ByteW-1:0] byte_eff;
  logic             in_acc, out_free;
  logic             restart_acc, keys_init, dec_emit;

  zcd_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign ks_word    = key2_q | KeyW'(2);
  assign key1_new   = prod + KeyW'(1);
  assign byte_eff   = (op_q == OP_DECRYPT) ? (byte_q ^ prod[2*ByteW-1:ByteW]) : byte_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    byte_d      = byte_q;
    key0_d      = key0_q;
    key1_d      = key1_q;
    key2_d      = key2_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_en      = 1'b0;
    mul_a       = ks_word;
    mul_b       = ks_word ^ KeyW'(1);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d   = in_data_i.operation;
          byte_d = in_data_i.data_byte;
          case (in_data_i.operation)
            OP_RESTART: begin
              key0_d = KEY_ZERO_INIT;
              key1_d = KEY_ONE_INIT;
              key2_d = KEY_TWO_INIT;
            end
            OP_ABSORB:  state_d = S_K0;
            OP_DECRYPT: state_d = S_KS;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_KS: begin
        // Keystream product (key2 | 2) * ((key2 | 2) ^ 1).
        mul_en  = 1'b1;
        state_d = S_K0;
      end
      S_K0: begin
        // A decrypt result waits here while the previous one is still stalled.
        if (op_q != OP_DECRYPT || out_free) begin
          key0_d  = crc_step(key0_q, byte_eff);
          state_d = S_K1;
          if (op_q == OP_DECRYPT) begin
            out_d.plain_byte    = byte_eff;
            out_d.matches_check = (byte_eff == check_q);
            out_valid_d         = 1'b1;
          end
        end
      end
      S_K1: begin
        mul_en  = 1'b1;
        mul_a   = key1_q + {{(KeyW-ByteW){1'b0}}, key0_q[ByteW-1:0]};
        mul_b   = KEY_ONE_MULT;
        state_d = S_K2;
      end
      S_K2: begin
        key1_d  = key1_new;
        key2_d  = crc_step(key2_q, key1_new[KeyW-1:KeyW-ByteW]);
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_RESTART;
      key0_q      <= KEY_ZERO_INIT;
      key1_q      <= KEY_ONE_INIT;
      key2_q      <= KEY_TWO_INIT;
      check_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      key0_q      <= key0_d;
      key1_q      <= key1_d;
      key2_q      <= key2_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        check_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign restart_acc = in_acc && (in_data_i.operation == OP_RESTART);
  assign keys_init   = (key0_q == KEY_ZERO_INIT) && (key2_q == KEY_TWO_INIT);
  assign dec_emit    = (state_q == S_K0) && (op_q == OP_DECRYPT) && out_free;

`include "zipcrypto_stream_decryptor_assert.svh"

  `ZCD_ASSERT_NEXT(a_restart_keys, restart_acc, keys_init && state_q == S_IDLE)
  `ZCD_ASSERT_NEXT(a_decrypt_result, dec_emit, out_valid_q && state_q == S_K1)
  `ZCD_ASSERT_NEXT(a_k2_returns, state_q == S_K2, state_q == S_IDLE && !in_stall_o)
  `ZCD_ASSERT_SAME(a_mul_idle, state_q != S_KS && state_q != S_K1, !mul_en)

endmodule

// ===== hdl/zcd_mul.sv =====
module zcd_mul
  import zcd_pkg::*;
(
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [KeyW-1:0] a_i,
  input  logic [KeyW-1:0] b_i,
  output logic [KeyW-1:0] prod_o
);

  logic [KeyW-1:0] prod_q;
  logic [KeyW-1:0] prod_d;

  // Only the low word of the product is ever needed.
  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== test/zipcrypto_stream_decryptor_tb.sv =====
module zipcrypto_stream_decryptor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import zcd_pkg::*;

  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 240;
  localparam int NUM_PHASES = 5;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [ByteW-1:0] data;
    logic             known;
    logic [ByteW-1:0] plain;
    logic             match;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [ByteW-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  zcd_in_t          in_data_i;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  zcd_out_t         out_data_o;

  // Key schedule mirror and the configured check byte.
  logic [KeyW-1:0]  pk_key0;
  logic [KeyW-1:0]  pk_key1;
  logic [KeyW-1:0]  pk_key2;
  logic [ByteW-1:0] check_value;

  zcd_out_t plain_expect_q [$];
  zcd_out_t want;
  bit       full_rate = 1'b0;
  int       error_cnt = 0;
  int       quiet_cycles = 0;
  int       restarts_sent = 0;
  int       absorbs_sent = 0;
  int       decrypts_sent = 0;
  int       ignored_sent = 0;
  int       results_seen = 0;
  int       matches_seen = 0;

  // After reset and after each restart the keystream byte is 0xAB, so a
  // ciphertext byte of 0xAB decrypts to zero, which equals the reset check byte.
  dir_row_t directed_rows [19] = '{
    '{OP_DECRYPT, 8'hAB, 1'b1, 8'h00, 1'b1},
    '{OP_RESTART, 8'h5A, 1'b0, 8'h00, 1'b0},
    '{OP_DECRYPT, 8'hAB, 1'b1, 8'h00, 1'b1},
    '{OP_DECRYPT, 8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_DECRYPT, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{OP_UNUSED,  8'hFF, 1'b0, 8'h00, 1'b0},
    '{OP_UNUSED,  8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_DECRYPT, 8'h3C, 1'b0, 8'h00, 1'b0},
    '{OP_RESTART, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{OP_ABSORB,  8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_ABSORB,  8'hFF, 1'b0, 8'h00, 1'b0},
    '{OP_ABSORB,  8'h55, 1'b0, 8'h00, 1'b0},
    '{OP_ABSORB,  8'hAA, 1'b0, 8'h00, 1'b0},
    '{OP_DECRYPT, 8'h55, 1'b0, 8'h00, 1'b0},
    '{OP_DECRYPT, 8'hAA, 1'b0, 8'h00, 1'b0},
    '{OP_DECRYPT, 8'h0F, 1'b0, 8'h00, 1'b0},
    '{OP_DECRYPT, 8'hF0, 1'b0, 8'h00, 1'b0},
    '{OP_RESTART, 8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_DECRYPT, 8'hAB, 1'b1, 8'h00, 1'b1}
  };

  zipcrypto_stream_decryptor DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [KeyW-1:0] crc_byte_update(logic [KeyW-1:0] crc,
                                                      logic [ByteW-1:0] b);
    logic [KeyW-1:0] x;
    x = {24'b0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      if (x[0]) begin
        x = (x >> 1) ^ CRC_POLY;
      end else begin
        x = x >> 1;
      end
    end
    return x ^ {8'b0, crc[31:8]};
  endfunction

  function automatic logic [ByteW-1:0] keystream_byte();
    logic [KeyW-1:0] t;
    logic [KeyW-1:0] p;
    t = pk_key2 | 32'd2;
    p = t * (t ^ 32'd1);
    return p[15:8];
  endfunction

  task automatic mix_key_byte(input logic [ByteW-1:0] b);
    pk_key0 = crc_byte_update(pk_key0, b);
    pk_key1 = (pk_key1 + {24'b0, pk_key0[7:0]}) * KEY_ONE_MULT + 32'd1;
    pk_key2 = crc_byte_update(pk_key2, pk_key1[31:24]);
  endtask

  task automatic load_initial_keys();
    pk_key0 = KEY_ZERO_INIT;
    pk_key1 = KEY_ONE_INIT;
    pk_key2 = KEY_TWO_INIT;
  endtask

  // Advances the key state for one accepted item; has_res tells if a plaintext
  // byte comes out.
  task automatic cipher_step(input zcd_in_t it, output bit has_res, output zcd_out_t res);
    logic [ByteW-1:0] plain;
    has_res = 1'b0;
    res = '0;
    case (it.operation)
      OP_RESTART: begin
        load_initial_keys();
        restarts_sent++;
      end
      OP_ABSORB: begin
        mix_key_byte(it.data_byte);
        absorbs_sent++;
      end
      OP_DECRYPT: begin
        plain = it.data_byte ^ keystream_byte();
        mix_key_byte(plain);
        res.plain_byte = plain;
        res.matches_check = (plain == check_value);
        has_res = 1'b1;
        decrypts_sent++;
      end
      default: begin
        ignored_sent++;
      end
    endcase
  endtask

  task automatic flag_mismatch(input string what);
    error_cnt++;
    if (error_cnt <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  task automatic send_item(input zcd_in_t it, input bit typed, input zcd_out_t typed_res);
    bit       has_res;
    zcd_out_t res;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    cipher_step(it, has_res, res);
    if (has_res) begin
      plain_expect_q.push_back(typed ? typed_res : res);
    end
  endtask

  task automatic maybe_gap();
    if (!full_rate && $urandom_range(0, 99) < 32) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Sends an item with an occasional ignored item slipped in ahead of it.
  task automatic feed(input zcd_in_t it);
    if ($urandom_range(0, 19) == 0) begin
      send_item({OP_UNUSED, ByteW'($urandom_range(0, 255))}, 1'b0, '0);
      maybe_gap();
    end
    send_item(it, 1'b0, '0);
    maybe_gap();
  endtask

  // Absorb items make no result, so idle cycles follow the last result.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (plain_expect_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_check(input logic [ByteW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    check_value = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly well-formed sessions: restart, a password, then a run of ciphertext.
  // Skipped restarts leave sessions that continue on stale keys.
  task automatic random_phase(input int count);
    int               sent;
    int               n;
    logic [ByteW-1:0] b;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) != 0) begin
        feed({OP_RESTART, ByteW'($urandom_range(0, 255))});
        sent++;
      end
      n = $urandom_range(0, 10);
      for (int i = 0; i < n; i++) begin
        feed({OP_ABSORB, ByteW'($urandom_range(0, 255))});
        sent++;
      end
      n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++) begin
        b = ByteW'($urandom_range(0, 255));
        if ($urandom_range(0, 5) == 0) begin
          b = check_value ^ keystream_byte();
        end
        feed({OP_DECRYPT, b});
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (plain_expect_q.size() == 0) begin
          flag_mismatch("result arrived with nothing expected");
        end else begin
          want = plain_expect_q.pop_front();
          results_seen++;
          if (want.matches_check) begin
            matches_seen++;
          end
          if (out_data_o.plain_byte !== want.plain_byte) begin
            flag_mismatch($sformatf("plain_byte %h, expected %h",
                                    out_data_o.plain_byte, want.plain_byte));
          end
          if (out_data_o.matches_check !== want.matches_check) begin
            flag_mismatch($sformatf("matches_check %b, expected %b",
                                    out_data_o.matches_check, want.matches_check));
          end
        end
      end
      out_stall_i <= full_rate ? 1'b0 : ($urandom_range(0, 99) < 32);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    dir_row_t         row;
    logic [ByteW-1:0] plan [NUM_PHASES];
    plan[0] = 8'hFF;
    plan[1] = 8'h00;
    plan[2] = ByteW'($urandom_range(0, 255));
    plan[3] = ByteW'($urandom_range(0, 255));
    plan[4] = 8'h7F;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    load_initial_keys();
    check_value = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_item({row.op, row.data}, row.known, {row.plain, row.match});
      maybe_gap();
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_check(plan[p]);
      // One phase runs with neither side ever holding back.
      full_rate = (p == 2);
      random_phase(PHASE_ITEMS);
    end
    full_rate = 1'b0;
    wait_drained();

    $display("Sent %0d restarts, %0d absorbs, %0d decrypts and %0d ignored items",
             restarts_sent, absorbs_sent, decrypts_sent, ignored_sent);
    $display("over %0d check byte settings; %0d results checked, %0d matched the check byte.",
             NUM_PHASES + 1, results_seen, matches_seen);
    if (error_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", error_cnt);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
